// ===== hdl/utx_pkg.sv =====
`timescale 1ns / 1ps

package utx_pkg;

  // Ring depth; the ring holds at most FIFO_DEPTH - 1 bytes.
  localparam int FIFO_DEPTH = 256;
  localparam int IDX_W      = $clog2(FIFO_DEPTH);

  localparam int DATA_W  = 8;
  localparam int FRAME_W = DATA_W + 2;

  // Item kinds.
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Shifter value right after a load: stop bit set, start bit clear.
  // The data bits are merged in from the memory in the following cycle.
  localparam logic [FRAME_W-1:0] FRAME_LOAD = {1'b1, {(FRAME_W - 1){1'b0}}};

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic tx_line;
    logic write_accepted;
    logic tx_idle;
  } result_t;

  // Next slot of the ring, wrapping at the depth.
  function automatic idx_t ring_next(input idx_t idx);
    idx_t res;
    if (idx == idx_t'(FIFO_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + idx_t'(1);
    end
    return res;
  endfunction

endpackage

// ===== hdl/utx_if.sv =====
`timescale 1ns / 1ps

// Input channel: one item is a tick or a byte write.
interface utx_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [utx_pkg::DATA_W-1:0]  data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

// Output channel: one result item per input item.
interface utx_rsp_if;
  logic valid;
  logic ready;
  logic tx_line;
  logic write_accepted;
  logic tx_idle;

  modport source (output valid, output tx_line, output write_accepted, output tx_idle,
                  input ready);
  modport sink   (input valid, input tx_line, input write_accepted, input tx_idle,
                  output ready);
endinterface

// ===== hdl/utx_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM with one write port and a registered read port.
module utx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/utx_core.sv =====
`timescale 1ns / 1ps

// Ring indices, frame shifter and line level around the byte memory.
module utx_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_data,
  input  logic                        step,
  input  logic                        req_type,
  input  logic [utx_pkg::DATA_W-1:0]  data_byte,
  output utx_pkg::result_t            result
);

  logic                          tx_enable;
  utx_pkg::idx_t                 wr_idx;
  utx_pkg::idx_t                 wr_idx_next;
  utx_pkg::idx_t                 rd_idx;
  utx_pkg::idx_t                 rd_idx_next;
  logic [utx_pkg::FRAME_W-1:0]   shifter;
  logic [utx_pkg::FRAME_W-1:0]   shifter_next;
  logic [utx_pkg::FRAME_W-1:0]   shifter_eff;
  logic                          pending;
  logic                          pending_next;
  logic                          line;
  logic                          line_next;
  logic                          accepted;
  utx_pkg::idx_t                 wr_slot;
  utx_pkg::idx_t                 rd_slot;
  logic                          ram_we;
  logic                          ram_re;
  logic [utx_pkg::DATA_W-1:0]    ram_rdata;

  assign wr_slot = utx_pkg::ring_next(wr_idx);
  assign rd_slot = utx_pkg::ring_next(rd_idx);

  utx_ram #(
    .WIDTH (utx_pkg::DATA_W),
    .DEPTH (utx_pkg::FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_slot),
    .wdata (data_byte),
    .re    (ram_re),
    .raddr (rd_slot),
    .rdata (ram_rdata)
  );

  // A frame loaded in the last cycle gets its data bits from the memory now.
  assign shifter_eff = pending ? {1'b1, ram_rdata, 1'b0} : shifter;

  // Next state for the item taken this cycle.
  always_comb begin
    wr_idx_next  = wr_idx;
    rd_idx_next  = rd_idx;
    shifter_next = shifter_eff;
    pending_next = 1'b0;
    line_next    = line;
    accepted     = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    if (step) begin
      if (req_type == utx_pkg::REQ_WRITE) begin
        if (wr_slot != rd_idx) begin
          ram_we      = 1'b1;
          accepted    = 1'b1;
          wr_idx_next = wr_slot;
        end
      end else if (tx_enable) begin
        if (shifter_eff != '0) begin
          line_next    = shifter_eff[0];
          shifter_next = shifter_eff >> 1;
        end else if (rd_idx != wr_idx) begin
          ram_re       = 1'b1;
          rd_idx_next  = rd_slot;
          shifter_next = utx_pkg::FRAME_LOAD;
          pending_next = 1'b1;
        end
      end
    end
  end

  assign result.tx_line        = line_next;
  assign result.write_accepted = accepted;
  assign result.tx_idle        = (rd_idx_next == wr_idx_next) && (shifter_next == '0);

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_enable <= 1'b0;
      wr_idx    <= '0;
      rd_idx    <= '0;
      shifter   <= '0;
      pending   <= 1'b0;
      line      <= 1'b1;
    end else begin
      if (cfg_write) begin
        tx_enable <= cfg_data;
      end
      wr_idx  <= wr_idx_next;
      rd_idx  <= rd_idx_next;
      shifter <= shifter_next;
      pending <= pending_next;
      line    <= line_next;
    end
  end

  // The memory read for a load is consumed in the very next cycle.
  a_pending_one_cycle: assert property (@(posedge clk) disable iff (rst)
    pending |=> !pending)
    else $error("load pending for more than one cycle");

  // While a load waits on the memory, the shifter holds only the framing bits.
  a_pending_shifter: assert property (@(posedge clk) disable iff (rst)
    pending |-> (shifter == utx_pkg::FRAME_LOAD))
    else $error("shifter changed while load pending");

  // A load only happens with the shifter empty and a byte queued.
  a_load_source: assert property (@(posedge clk) disable iff (rst)
    pending_next |-> (shifter_eff == '0) && (rd_idx != wr_idx))
    else $error("load without queued byte or with busy shifter");

  // An accepted write advances the write index by one slot.
  a_write_advance: assert property (@(posedge clk) disable iff (rst)
    accepted |=> (wr_idx == $past(wr_slot)))
    else $error("accepted write did not advance write index");

endmodule

// ===== hdl/uart_tx_with_fifo_unit.sv =====
`timescale 1ns / 1ps

// Serial 8N1 transmitter fed from a byte ring.
// Channel req carries items: req_type 0 is one bit-time tick, req_type 1 writes
// data_byte into the ring. Channel rsp returns exactly one result item per
// request item: the line level after the item, whether a write stored its byte
// (the ring refuses writes once it holds FIFO_DEPTH - 1 bytes), and whether the
// ring and the shifter are both empty.
// cfg_write with cfg_data sets tx_enable; while it is 0 ticks change nothing.
// The result of an item accepted at one edge is registered, valid after it.
// Throughput is one item per cycle unless rsp stalls; a tick that starts a
// frame reads the byte memory, merging the data bits next cycle without stall.
// A single output register holds the result; req.ready stays high while that
// register is empty or being taken, so a stalled receiver stalls the input
// after one buffered result and nothing is lost.
// Reset (rst, synchronous) empties the ring, clears the shifter, drives the
// line high and disables ticks. The ring memory itself is not cleared.
module uart_tx_with_fifo_unit (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic      cfg_data,
  utx_req_if.sink   req,
  utx_rsp_if.source rsp
);

  logic             step;
  logic             out_valid;
  utx_pkg::result_t core_result;
  utx_pkg::result_t out_result;

  assign req.ready = !out_valid || rsp.ready;
  assign step      = req.valid && req.ready;

  utx_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .step      (step),
    .req_type  (req.req_type),
    .data_byte (req.data_byte),
    .result    (core_result)
  );

  // Output register for the result item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= core_result;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.tx_line        = out_result.tx_line;
  assign rsp.write_accepted = out_result.write_accepted;
  assign rsp.tx_idle        = out_result.tx_idle;

endmodule

// ===== dv/tb_uart_tx_with_fifo_unit.sv =====
`timescale 1ns / 1ps

module tb_uart_tx_with_fifo_unit;

  localparam int HALF_PERIOD  = 6;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int MAX_WAIT     = 19;
  localparam int MAX_REPORTS  = 10;
  localparam int DIR_ROWS     = 22;

  // Kinds of rows in the directed stimulus table.
  typedef enum logic [1:0] {ROW_TICK, ROW_WRITE, ROW_CFG} row_kind_t;

  // One directed row: an item repeated reps times, or an enable write (data bit 0).
  // When typed is set, want is the expected result instead of the prediction.
  typedef struct {
    row_kind_t                  kind;
    logic [utx_pkg::DATA_W-1:0] data;
    int                         reps;
    bit                         typed;
    utx_pkg::result_t           want;
  } stim_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_data  = 1'b0;

  utx_req_if req_ch ();
  utx_rsp_if rsp_ch ();

  uart_tx_with_fifo_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Predicted transmitter state.
  logic [utx_pkg::DATA_W-1:0]  ring_copy [utx_pkg::FIFO_DEPTH];
  utx_pkg::idx_t               head_idx;
  utx_pkg::idx_t               tail_idx;
  logic [utx_pkg::FRAME_W-1:0] frame_bits;
  logic                        line_bit;
  logic                        ticks_on;

  // Expected results, oldest first.
  utx_pkg::result_t tx_results_q [$];

  int mismatches  = 0;
  int cycle_count = 0;

  // When set, the sender or the receiver runs without gaps for a stretch.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  function automatic utx_pkg::idx_t ring_succ(input utx_pkg::idx_t i);
    return utx_pkg::idx_t'((int'(i) + 1) % utx_pkg::FIFO_DEPTH);
  endfunction

  // Applies one item to the predicted state and returns the result it causes.
  function automatic utx_pkg::result_t advance_tx(input logic kind,
                                                  input logic [utx_pkg::DATA_W-1:0] data);
    utx_pkg::result_t res;
    utx_pkg::idx_t    slot;
    res.write_accepted = 1'b0;
    if (kind == utx_pkg::REQ_WRITE) begin
      slot = ring_succ(head_idx);
      if (slot != tail_idx) begin
        ring_copy[slot]    = data;
        head_idx           = slot;
        res.write_accepted = 1'b1;
      end
    end else if (ticks_on) begin
      if (frame_bits != '0) begin
        line_bit   = frame_bits[0];
        frame_bits = frame_bits >> 1;
      end else if (tail_idx != head_idx) begin
        // Loading tick: start bit low, data LSB first, stop bit high.
        slot       = ring_succ(tail_idx);
        frame_bits = {1'b1, ring_copy[slot], 1'b0};
        tail_idx   = slot;
      end
    end
    res.tx_line = line_bit;
    res.tx_idle = (tail_idx == head_idx) && (frame_bits == '0);
    return res;
  endfunction

  // Offers one item after a random gap and records its expected result once taken.
  task automatic send_item(input logic kind, input logic [utx_pkg::DATA_W-1:0] data,
                           input bit typed, input utx_pkg::result_t want);
    int               gap;
    utx_pkg::result_t predicted;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.data_byte <= data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = advance_tx(kind, data);
    tx_results_q.push_back(typed ? want : predicted);
  endtask

  // Writes tx_enable once every outstanding result has come back.
  task automatic set_enable(input logic value);
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (tx_results_q.size() != 0);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    ticks_on = value;
  endtask

  // Stimulus: directed table first, then random phases.
  initial begin
    stim_row_t dir_rows [DIR_ROWS];
    int        sent;
    int        phase_len;
    int        wr_pct;
    logic      en;
    logic      kind;

    req_ch.valid     = 1'b0;
    req_ch.req_type  = utx_pkg::REQ_TICK;
    req_ch.data_byte = '0;
    head_idx         = '0;
    tail_idx         = '0;
    frame_bits       = '0;
    line_bit         = 1'b1;
    ticks_on         = 1'b0;

    dir_rows = '{
      '{ROW_TICK,  8'h00, 1,   1'b1, 3'b101}, // tick while disabled after reset
      '{ROW_CFG,   8'h01, 0,   1'b0, 3'b000},
      '{ROW_TICK,  8'h00, 1,   1'b1, 3'b101}, // tick with nothing queued
      '{ROW_WRITE, 8'h00, 1,   1'b1, 3'b110},
      '{ROW_WRITE, 8'hFF, 1,   1'b0, 3'b000},
      '{ROW_TICK,  8'h00, 1,   1'b1, 3'b100}, // loading tick holds the line
      '{ROW_TICK,  8'h00, 22,  1'b0, 3'b000}, // both frames go out
      '{ROW_TICK,  8'h00, 1,   1'b1, 3'b101},
      '{ROW_CFG,   8'h00, 0,   1'b0, 3'b000},
      '{ROW_WRITE, 8'h01, 255, 1'b0, 3'b000}, // writes while disabled fill the ring
      '{ROW_WRITE, 8'h5A, 1,   1'b1, 3'b100}, // full ring refuses the write
      '{ROW_TICK,  8'h00, 1,   1'b1, 3'b100},
      '{ROW_CFG,   8'h01, 0,   1'b0, 3'b000},
      '{ROW_TICK,  8'h00, 33,  1'b0, 3'b000}, // three frames leave the full ring
      '{ROW_WRITE, 8'h80, 1,   1'b0, 3'b000}, // freed slot takes a write again
      '{ROW_TICK,  8'h00, 5,   1'b0, 3'b000},
      '{ROW_CFG,   8'h00, 0,   1'b0, 3'b000},
      '{ROW_TICK,  8'h00, 3,   1'b0, 3'b000}, // disabled in mid frame
      '{ROW_CFG,   8'h01, 0,   1'b0, 3'b000},
      '{ROW_TICK,  8'h00, 12,  1'b0, 3'b000},
      '{ROW_WRITE, 8'h7F, 1,   1'b0, 3'b000},
      '{ROW_TICK,  8'h55, 12,  1'b0, 3'b000}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        set_enable(dir_rows[r].data[0]);
      end else begin
        for (int k = 0; k < dir_rows[r].reps; k++) begin
          send_item((dir_rows[r].kind == ROW_WRITE) ? utx_pkg::REQ_WRITE : utx_pkg::REQ_TICK,
                    utx_pkg::DATA_W'(int'(dir_rows[r].data) + k), dir_rows[r].typed,
                    dir_rows[r].want);
        end
      end
    end

    // Random phases: each sets the enable, a write mix and the gap behavior.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 160);
      case ($urandom_range(0, 3))
        0: begin
          wr_pct = 8;
        end
        1: begin
          wr_pct = 30;
        end
        2: begin
          wr_pct = 60;
        end
        default: begin
          wr_pct = 95;
        end
      endcase
      en = ($urandom_range(0, 3) != 0);
      // Disabled ticks do nothing, so disabled phases mostly write.
      if (!en) begin
        wr_pct = 85;
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      set_enable(en);
      repeat (phase_len) begin
        kind = ($urandom_range(0, 99) < wr_pct) ? utx_pkg::REQ_WRITE : utx_pkg::REQ_TICK;
        send_item(kind, utx_pkg::DATA_W'($urandom_range(0, 255)), 1'b0, '0);
        sent++;
      end
    end

    // Drain, then give stray results a chance to show up.
    req_ch.valid <= 1'b0;
    while (tx_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && tx_results_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result receiver: random stall before taking each item.
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // Compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    utx_pkg::result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (tx_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result with none expected: line=%0b accepted=%0b idle=%0b",
                   $time, rsp_ch.tx_line, rsp_ch.write_accepted, rsp_ch.tx_idle);
        end
      end else begin
        want = tx_results_q.pop_front();
        if (rsp_ch.tx_line !== want.tx_line || rsp_ch.write_accepted !== want.write_accepted
            || rsp_ch.tx_idle !== want.tx_idle) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: mismatch: expected line=%0b accepted=%0b idle=%0b, %s%0b %0b %0b",
                     $time, want.tx_line, want.write_accepted, want.tx_idle, "got ",
                     rsp_ch.tx_line, rsp_ch.write_accepted, rsp_ch.tx_idle);
          end
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
